// ===== design/tcq_pkg.sv =====
// tcq_pkg: shared types and constants for the two-class ticket queue
// used by tcq_ctrl, tcq_dpath and two_class_ticket_queue
package tcq_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned TICKET_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  localparam logic [TICKET_W-1:0] TICKET_MAX = '1;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ_NORMAL   = 2'd0,
    CMD_ENQ_PRIORITY = 2'd1,
    CMD_DEQUEUE      = 2'd2,
    CMD_NONE         = 2'd3
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // one queue entry
  typedef struct packed {
    logic                prio;
    logic [TICKET_W-1:0] ticket;
    logic [CODE_W-1:0]   code;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_hold;
  } dp_stat_t;

endpackage

// ===== design/tcq_ctrl.sv =====
// tcq_ctrl: request sequencer for the two-class ticket queue
// depends on tcq_pkg; drives tcq_dpath through dp_cmd_t
module tcq_ctrl import tcq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  dp_stat_t stat_i,
  output logic     in_stall_o,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!stat_i.res_hold) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.execute = !stat_i.res_hold;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/tcq_dpath.sv =====
// tcq_dpath: entry row, counters, ticket logic and result register
// depends on tcq_pkg; sequenced by tcq_ctrl
module tcq_dpath import tcq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [CMD_W-1:0]    in_cmd_i,
  input  logic [CODE_W-1:0]   in_counter_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [TICKET_W-1:0] out_ticket_o,
  output logic [CODE_W-1:0]   out_counter_code_o,
  output logic                out_priority_o,
  output logic                out_queue_empty_o,
  output logic [OCC_W-1:0]    out_occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef struct packed {
    status_e             status;
    logic [TICKET_W-1:0] ticket;
    logic [CODE_W-1:0]   code;
    logic                prio;
    logic                empty;
    logic [OCC_W-1:0]    occ;
  } result_t;

  cmd_e                cmd_q;
  logic [CODE_W-1:0]   code_q;
  logic [TICKET_W-1:0] tkt_q, tkt_d;
  logic [CntW-1:0]     hc_q, hc_d, pc_q, pc_d;
  logic [TICKET_W-1:0] lastp_q, lastp_d, lastn_q, lastn_d;
  entry_t              cell_q [DEPTH];
  entry_t              cell_d [DEPTH];
  result_t             res_q, res_d;
  logic                out_valid_q;

  logic                full, empty, do_ins, do_deq;
  logic [CntW-1:0]     pos;
  entry_t              new_entry;
  logic [TICKET_W-1:0] best_p, best_n, best;

  // largest held ticket: each run is in enqueue order, so its last entry holds its maximum
  always_comb begin
    best_p = (pc_q != '0) ? lastp_q : '0;
    best_n = (hc_q != pc_q) ? lastn_q : '0;
    best   = (best_p > best_n) ? best_p : best_n;
    if (hc_q == '0) begin
      tkt_d = TICKET_W'(1);
    end else if (best == TICKET_MAX) begin
      tkt_d = TICKET_MAX;
    end else begin
      tkt_d = best + TICKET_W'(1);
    end
  end

  // capture the item and its ticket
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      code_q <= in_counter_code_i;
      tkt_q  <= tkt_d;
    end
  end

  // operation decode
  always_comb begin
    full      = (hc_q == CntW'(DEPTH));
    empty     = (hc_q == '0);
    do_ins    = 1'b0;
    do_deq    = 1'b0;
    pos       = hc_q;
    new_entry = '{prio: 1'b0, ticket: tkt_q, code: code_q};
    res_d     = '{status: ST_DONE, ticket: '0, code: '0, prio: 1'b0,
                  empty: 1'b0, occ: '0};
    unique case (cmd_q)
      CMD_ENQ_NORMAL: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          do_ins       = 1'b1;
          res_d.ticket = tkt_q;
        end
      end
      CMD_ENQ_PRIORITY: begin
        pos            = pc_q;
        new_entry.prio = 1'b1;
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          do_ins       = 1'b1;
          res_d.ticket = tkt_q;
        end
      end
      CMD_DEQUEUE: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          do_deq       = 1'b1;
          res_d.ticket = cell_q[0].ticket;
          res_d.code   = cell_q[0].code;
          res_d.prio   = cell_q[0].prio;
        end
      end
      CMD_NONE: begin
        res_d.status = ST_DONE;
      end
      default: begin
        res_d.status = ST_DONE;
      end
    endcase
  end

  // counters and last tickets of each run
  always_comb begin
    hc_d    = hc_q;
    pc_d    = pc_q;
    lastp_d = lastp_q;
    lastn_d = lastn_q;
    if (do_ins) begin
      hc_d = hc_q + CntW'(1);
      if (new_entry.prio) begin
        pc_d    = pc_q + CntW'(1);
        lastp_d = tkt_q;
      end else begin
        lastn_d = tkt_q;
      end
    end else if (do_deq) begin
      hc_d = hc_q - CntW'(1);
      if (cell_q[0].prio && pc_q != '0) pc_d = pc_q - CntW'(1);
    end
    res_d.empty = (hc_d == '0);
    res_d.occ   = OCC_W'(hc_d);
  end

  // entry row: insert opens a gap at pos, dequeue shifts toward the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CntW-1:0] idx;
    assign idx = CntW'(i);
    always_comb begin
      cell_d[i] = cell_q[i];
      if (do_ins) begin
        if (idx == pos) begin
          cell_d[i] = new_entry;
        end else if (idx > pos) begin
          if (i > 0) cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_deq) begin
        if (i < DEPTH - 1) cell_d[i] = cell_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.execute) cell_q[i] <= cell_d[i];
    end
  end

  // run tickets hold payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      lastp_q <= lastp_d;
      lastn_q <= lastn_d;
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
      pc_q <= '0;
    end else if (cmd_i.execute) begin
      hc_q <= hc_d;
      pc_q <= pc_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.res_hold    = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_status_o       = res_q.status;
  assign out_ticket_o       = res_q.ticket;
  assign out_counter_code_o = res_q.code;
  assign out_priority_o     = res_q.prio;
  assign out_queue_empty_o  = res_q.empty;
  assign out_occupancy_o    = res_q.occ;

endmodule

// ===== design/two_class_ticket_queue.sv =====
// two_class_ticket_queue: top level of the two-class ticket queue
// depends on tcq_pkg, tcq_ctrl and tcq_dpath
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+-----
//   in      | in_valid_i, in_stall_o, in_cmd_i,                | in
//           | in_counter_code_i                                |
//   out     | out_valid_o, out_stall_i, out_status_o,          | out
//           | out_ticket_o, out_counter_code_o, out_priority_o,|
//           | out_queue_empty_o, out_occupancy_o               |
//
// each item is taken in a capture step that forms the next ticket from the
// last ticket of each run; an update step then writes the row and counters
// one item is in work at a time; in_stall_o is high during the update cycle
// the result register lets the next item be accepted while a result waits;
// the update cycle is held off while the previous result is still stalled
// reset clears the counters and the controller; the entry row is not cleared
module two_class_ticket_queue import tcq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    in_cmd_i,
  input  logic [CODE_W-1:0]   in_counter_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [TICKET_W-1:0] out_ticket_o,
  output logic [CODE_W-1:0]   out_counter_code_o,
  output logic                out_priority_o,
  output logic                out_queue_empty_o,
  output logic [OCC_W-1:0]    out_occupancy_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer
  tcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (dp_stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (dp_cmd)
  );

  // entry row and result register
  tcq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .stat_o             (dp_stat),
    .in_cmd_i           (in_cmd_i),
    .in_counter_code_i  (in_counter_code_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_ticket_o       (out_ticket_o),
    .out_counter_code_o (out_counter_code_o),
    .out_priority_o     (out_priority_o),
    .out_queue_empty_o  (out_queue_empty_o),
    .out_occupancy_o    (out_occupancy_o)
  );

  // one item in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is in work");

  // dropped enqueue carries no ticket and reports a full queue
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == ST_FULL) |->
      (out_ticket_o == '0 && out_occupancy_o == OCC_W'(DEPTH) && !out_queue_empty_o))
    else $error("full result inconsistent");

  // dequeue on empty queue leaves it empty with no payload
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == ST_EMPTY) |->
      (out_queue_empty_o && out_ticket_o == '0 && out_counter_code_o == '0))
    else $error("empty result inconsistent");

  // a stalled result stays valid and unchanged
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_status_o) && $stable(out_ticket_o) &&
       $stable(out_counter_code_o) && $stable(out_priority_o) &&
       $stable(out_queue_empty_o) && $stable(out_occupancy_o)))
    else $error("stalled result changed");

endmodule

// ===== bench/two_class_ticket_queue_tb.sv =====
// two_class_ticket_queue_tb: self-checking bench for the two-class ticket queue
// holds its own shadow of the entry row and counters; needs tcq_pkg and the RTL
// runs a directed table, a random mix with a long output hold-off, then a drain
module two_class_ticket_queue_tb;
  import tcq_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned RANDOM_ITEMS   = 700;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // one result as the block reports it
  typedef struct {
    status_e             status;
    logic [TICKET_W-1:0] ticket;
    logic [CODE_W-1:0]   code;
    logic                prio;
    logic                empty;
    logic [OCC_W-1:0]    occ;
  } result_t;

  // one row of the directed table
  typedef struct {
    cmd_e              cmd;
    logic [CODE_W-1:0] code;
    bit                fixed;
    result_t           want;
  } drill_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    in_cmd_i = CMD_NONE;
  logic [CODE_W-1:0]   in_counter_code_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] out_status_o;
  logic [TICKET_W-1:0] out_ticket_o;
  logic [CODE_W-1:0]   out_counter_code_o;
  logic                out_priority_o;
  logic                out_queue_empty_o;
  logic [OCC_W-1:0]    out_occupancy_o;

  // shadow of the queue contents
  entry_t shadow_row [DEPTH];
  int     shadow_held = 0;
  int     shadow_prio_cnt = 0;

  result_t    awaited_results [$];
  drill_row_t drill_rows [$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned full_drops = 0;
  int unsigned empty_pops = 0;
  int unsigned saturated_grants = 0;
  int unsigned peak_occ = 0;
  bit          squeeze_done = 1'b0;
  int unsigned squeeze_left = 0;
  int unsigned stall_left = 0;
  int unsigned flow_left = 0;

  two_class_ticket_queue #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_cmd_i           (in_cmd_i),
    .in_counter_code_i  (in_counter_code_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_ticket_o       (out_ticket_o),
    .out_counter_code_o (out_counter_code_o),
    .out_priority_o     (out_priority_o),
    .out_queue_empty_o  (out_queue_empty_o),
    .out_occupancy_o    (out_occupancy_o)
  );

  always #6 clk_i = ~clk_i;

  // apply one request to the shadow queue and return what the block should report
  function automatic result_t apply_request(cmd_e c, logic [CODE_W-1:0] code);
    result_t             r;
    logic [TICKET_W-1:0] top;
    logic [TICKET_W-1:0] grant;
    int                  pos;
    int                  i;
    r.status = ST_DONE;
    r.ticket = '0;
    r.code   = '0;
    r.prio   = 1'b0;
    case (c) inside
      CMD_ENQ_NORMAL, CMD_ENQ_PRIORITY: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // next ticket: one above the largest held, 1 on empty, capped at max
          top = '0;
          for (i = 0; i < shadow_held; i++)
            if (shadow_row[i].ticket > top) top = shadow_row[i].ticket;
          if (shadow_held == 0) grant = TICKET_W'(1);
          else if (top == TICKET_MAX) grant = TICKET_MAX;
          else grant = top + 1'b1;
          // priority entries go after the priority run, normal ones at the tail
          pos = (c == CMD_ENQ_PRIORITY) ? shadow_prio_cnt : shadow_held;
          if (pos > shadow_held) pos = shadow_held;
          for (i = shadow_held; i > pos; i--) shadow_row[i] = shadow_row[i-1];
          shadow_row[pos].prio   = (c == CMD_ENQ_PRIORITY);
          shadow_row[pos].ticket = grant;
          shadow_row[pos].code   = code;
          shadow_held++;
          if (c == CMD_ENQ_PRIORITY) shadow_prio_cnt++;
          r.ticket = grant;
        end
      end
      CMD_DEQUEUE: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.ticket = shadow_row[0].ticket;
          r.code   = shadow_row[0].code;
          r.prio   = shadow_row[0].prio;
          for (i = 1; i < shadow_held; i++) shadow_row[i-1] = shadow_row[i];
          shadow_held--;
          if (r.prio && shadow_prio_cnt > 0) shadow_prio_cnt--;
        end
      end
      default: ;
    endcase
    r.empty = (shadow_held == 0);
    r.occ   = shadow_held[OCC_W-1:0];
    return r;
  endfunction

  // directed rows: plain ones are predicted, fixed ones carry a typed result
  function automatic void add_row(cmd_e c, logic [CODE_W-1:0] code);
    drill_row_t row;
    row.cmd   = c;
    row.code  = code;
    row.fixed = 1'b0;
    drill_rows.push_back(row);
  endfunction

  function automatic void add_fixed(cmd_e c, logic [CODE_W-1:0] code, status_e st,
                                    logic [TICKET_W-1:0] tk, logic em, logic [OCC_W-1:0] occ);
    drill_row_t row;
    row.cmd         = c;
    row.code        = code;
    row.fixed       = 1'b1;
    row.want.status = st;
    row.want.ticket = tk;
    row.want.code   = '0;
    row.want.prio   = 1'b0;
    row.want.empty  = em;
    row.want.occ    = occ;
    drill_rows.push_back(row);
  endfunction

  // sender gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(input cmd_e c, input logic [CODE_W-1:0] code,
                           input int unsigned gap, output result_t pred);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_cmd_i          <= c;
    in_counter_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = apply_request(c, code);
    items_sent++;
    if (pred.status == ST_FULL) full_drops++;
    if (pred.status == ST_EMPTY) empty_pops++;
    if (c inside {CMD_ENQ_NORMAL, CMD_ENQ_PRIORITY} && pred.status == ST_DONE &&
        pred.ticket == TICKET_MAX)
      saturated_grants++;
    if (shadow_held > peak_occ) peak_occ = shadow_held;
    @(negedge clk_i);
  endtask

  function automatic void report_miss(string what, logic [TICKET_W-1:0] want,
                                      logic [TICKET_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d, %s: expected %0h, got %0h",
               results_seen, what, want, got);
  endfunction

  // result checker
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_e'(out_status_o);
      got.ticket = out_ticket_o;
      got.code   = out_counter_code_o;
      got.prio   = out_priority_o;
      got.empty  = out_queue_empty_o;
      got.occ    = out_occupancy_o;
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: nothing pending, got status %0d ticket %0h",
                   results_seen, got.status, got.ticket);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          report_miss("status", TICKET_W'(want.status), TICKET_W'(got.status));
        if (got.ticket !== want.ticket) report_miss("ticket", want.ticket, got.ticket);
        if (got.code !== want.code)
          report_miss("counter code", TICKET_W'(want.code), TICKET_W'(got.code));
        if (got.prio !== want.prio)
          report_miss("priority", TICKET_W'(want.prio), TICKET_W'(got.prio));
        if (got.empty !== want.empty)
          report_miss("queue empty", TICKET_W'(want.empty), TICKET_W'(got.empty));
        if (got.occ !== want.occ)
          report_miss("occupancy", TICKET_W'(want.occ), TICKET_W'(got.occ));
      end
    end
  end

  // receiver: random stalls, free-flowing stretches and one long hold-off
  always @(negedge clk_i) begin : receiver
    logic hold;
    hold = 1'b0;
    if (squeeze_left > 0) begin
      hold = 1'b1;
      squeeze_left--;
    end else if (!squeeze_done && results_seen >= 150) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_CYCLES - 1;
      hold = 1'b1;
    end else if (stall_left > 0) begin
      hold = 1'b1;
      stall_left--;
    end else if (flow_left > 0) begin
      flow_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      flow_left = $urandom_range(30, 80);
    end else begin
      flow_left  = $urandom_range(0, 6);
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    end
    out_stall_i <= hold;
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d still pending",
               quiet_cycles, awaited_results.size());
      $display("two_class_ticket_queue_tb failed");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    result_t           pred;
    cmd_e              c;
    logic [CODE_W-1:0] code;
    int unsigned       r;
    int unsigned       enq_bias;
    bit                idle_on;

    // empty queue, unused command, first tickets
    add_fixed(CMD_DEQUEUE, 8'h00, ST_EMPTY, 16'd0, 1'b1, 5'd0);
    add_fixed(CMD_NONE, 8'hFF, ST_DONE, 16'd0, 1'b1, 5'd0);
    add_fixed(CMD_ENQ_NORMAL, 8'h00, ST_DONE, 16'd1, 1'b0, 5'd1);
    add_fixed(CMD_ENQ_PRIORITY, 8'hFF, ST_DONE, 16'd2, 1'b0, 5'd2);
    // fill up with a mix of both classes
    for (int k = 0; k < 14; k++)
      add_row((k % 3 == 1) ? CMD_ENQ_PRIORITY : CMD_ENQ_NORMAL, 8'(k * 37 + 5));
    // full queue drops both classes, unused command leaves it alone
    add_fixed(CMD_ENQ_NORMAL, 8'h55, ST_FULL, 16'd0, 1'b0, 5'd16);
    add_fixed(CMD_ENQ_PRIORITY, 8'hAA, ST_FULL, 16'd0, 1'b0, 5'd16);
    add_fixed(CMD_NONE, 8'h3C, ST_DONE, 16'd0, 1'b0, 5'd16);
    add_row(CMD_DEQUEUE, 8'hC3);
    add_row(CMD_DEQUEUE, 8'h00);
    add_row(CMD_ENQ_PRIORITY, 8'h7E);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (drill_rows[k]) begin
      send_item(drill_rows[k].cmd, drill_rows[k].code, pick_gap(1'b1), pred);
      if (drill_rows[k].fixed) awaited_results.push_back(drill_rows[k].want);
      else awaited_results.push_back(pred);
    end

    // random mix, enqueue bias and idling change every chunk
    enq_bias = 50;
    idle_on  = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        enq_bias = $urandom_range(25, 85);
        idle_on  = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) c = CMD_NONE;
      else if (r < enq_bias)
        c = ($urandom_range(0, 2) == 0) ? CMD_ENQ_PRIORITY : CMD_ENQ_NORMAL;
      else c = CMD_DEQUEUE;
      r = $urandom_range(0, 19);
      if (r == 0) code = 8'h00;
      else if (r == 1) code = 8'hFF;
      else code = 8'($urandom_range(0, 255));
      send_item(c, code, pick_gap(idle_on), pred);
      awaited_results.push_back(pred);
    end

    // drain, one dequeue past empty
    while (shadow_held > 0) begin
      send_item(CMD_DEQUEUE, 8'($urandom_range(0, 255)), 0, pred);
      awaited_results.push_back(pred);
    end
    send_item(CMD_DEQUEUE, 8'h00, 0, pred);
    awaited_results.push_back(pred);
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d requests and %0d results in %0d cycles, peak occupancy %0d",
             items_sent, results_seen, cycle_count, peak_occ);
    $display("full drops %0d, empty dequeues %0d, saturated tickets %0d, mismatches %0d",
             full_drops, empty_pops, saturated_grants, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("two_class_ticket_queue_tb passed");
    end else begin
      $display("two_class_ticket_queue_tb failed");
    end
    $finish;
  end

endmodule
